@@ src/epsc_pkg.sv @@
package epsc_pkg;

  // pipeline depth, from the input register to the result register
  localparam int NSTAGE = 10;

  // stage indices shared by the datapath modules
  localparam int STG_DAY_SPLIT = 2;
  localparam int STG_DATE_IN   = 3;
  localparam int STG_LAST      = NSTAGE - 1;

  // seconds per day is 2^7 * 675, so the day split divides t >> 7 by 675
  localparam logic [22:0] DAY_RECIP    = 23'd6362914;  // floor(2^32 / 675)
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;

  // time of day reciprocals, exact over the ranges they see
  localparam logic [15:0] HOUR_RECIP    = 16'd37283;   // ceil(2^27 / 3600)
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [12:0] MIN_RECIP     = 13'd4370;    // ceil(2^18 / 60)
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

  // civil-from-days constants
  localparam logic [19:0] SHIFT_TO_MARCH = 20'd719468;
  localparam logic [19:0] ERA5_START     = 20'd730485; // 5 * 146097
  localparam logic [19:0] ERA4_START     = 20'd584388; // 4 * 146097
  localparam logic [17:0] DOE_CENTURY1   = 18'd36524;
  localparam logic [17:0] DOE_CENTURY2   = 18'd73048;
  localparam logic [17:0] DOE_CENTURY3   = 18'd109572;
  localparam logic [17:0] DOE_LAST       = 18'd146096;
  localparam logic [15:0] QUAD_RECIP     = 16'd45965;  // ceil(2^24 / 365)
  localparam logic [17:0] YEAR_RECIP     = 18'd183860; // ceil(2^26 / 365)
  localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
  localparam logic [5:0]  CENT_RECIP     = 6'd41;      // ceil(2^12 / 100)
  localparam logic [12:0] MONTH_RECIP    = 13'd6854;   // ceil(2^20 / 153)
  localparam logic [11:0] ERA4_YEAR      = 12'd1600;
  localparam logic [11:0] ERA5_YEAR      = 12'd2000;

  typedef logic [15:0] days_t;
  typedef logic [16:0] sod_t;

  // per-stage load enables and valid bits
  typedef struct packed {
    logic [NSTAGE-1:0] en;
    logic [NSTAGE-1:0] vld;
  } pipe_ctl_t;

  // first day of each month in a march-based year, (153 * mp + 2) / 5
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ src/epsc_if.sv @@
interface epsc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface epsc_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source (output valid, output year, output month, output day,
                  output hour, output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day,
                  input hour, input minute, input second, output ready);
endinterface

@@ src/epsc_pipe_ctrl.sv @@
module epsc_pipe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               out_ready,
  output logic               in_ready,
  output logic               out_valid,
  output epsc_pkg::pipe_ctl_t ctl
);
  import epsc_pkg::*;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  // a stage loads when it is empty or its successor loads, so bubbles close up
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  // valid bits move with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTAGE-1];
  assign ctl.en    = en;
  assign ctl.vld   = vld;

  // accepted item lands in the first stage
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && en[0]) |=> vld[0])
    else $error("accepted item missing from first stage");

  // a full pipeline stalled at the output takes no new item
  assert property (@(posedge clk) disable iff (rst)
    (&vld && !out_ready) |-> !in_ready)
    else $error("full pipeline accepted an item while stalled");

endmodule

@@ src/epsc_day_split.sv @@
module epsc_day_split (
  input  logic                clk,
  input  epsc_pkg::pipe_ctl_t ctl,
  input  logic [31:0]         epoch_seconds,
  output epsc_pkg::days_t     days,
  output epsc_pkg::sod_t      sod
);
  import epsc_pkg::*;

  logic [47:0] prod0;
  logic [31:0] t0;
  logic [15:0] q1;
  logic [17:0] rem1;
  logic [15:0] q_est;

  // stage 0: reciprocal product of t / 128 by 1 / 675
  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      prod0 <= 48'(epoch_seconds[31:7]) * 48'(DAY_RECIP);
      t0    <= epoch_seconds;
    end
  end

  // stage 1: quotient estimate is exact or one short; form its remainder
  assign q_est = prod0[47:32];

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      q1   <= q_est;
      rem1 <= 18'(t0 - 32'(q_est) * 32'(SECS_PER_DAY));
    end
  end

  // stage 2: one correction step
  always_ff @(posedge clk) begin
    if (ctl.en[STG_DAY_SPLIT]) begin
      if (rem1 >= 18'(SECS_PER_DAY)) begin
        days <= q1 + 16'd1;
        sod  <= 17'(rem1 - 18'(SECS_PER_DAY));
      end else begin
        days <= q1;
        sod  <= rem1[16:0];
      end
    end
  end

endmodule

@@ src/epsc_time_of_day.sv @@
module epsc_time_of_day (
  input  logic                clk,
  input  logic                rst,
  input  epsc_pkg::pipe_ctl_t ctl,
  input  epsc_pkg::sod_t      sod,
  output logic [4:0]          hour,
  output logic [5:0]          minute,
  output logic [5:0]          second
);
  import epsc_pkg::*;

  localparam int FIRST = STG_DATE_IN;
  localparam int DLY   = STG_LAST - (FIRST + 3);

  logic [31:0] hprod;
  sod_t        sod3;
  logic [4:0]  h4;
  logic [11:0] rs4;
  logic [23:0] mprod;
  logic [4:0]  h5;
  logic [11:0] rs5;
  logic [5:0]  m_est;
  logic [4:0]  h_dly [DLY+1];
  logic [5:0]  m_dly [DLY+1];
  logic [5:0]  s_dly [DLY+1];

  // hour by reciprocal
  always_ff @(posedge clk) begin
    if (ctl.en[FIRST]) begin
      hprod <= 32'(sod) * 32'(HOUR_RECIP);
      sod3  <= sod;
    end
  end

  // seconds within the hour
  always_ff @(posedge clk) begin
    if (ctl.en[FIRST+1]) begin
      h4  <= hprod[31:27];
      rs4 <= 12'(sod3 - 17'(hprod[31:27]) * 17'(SECS_PER_HOUR));
    end
  end

  // minute by reciprocal
  always_ff @(posedge clk) begin
    if (ctl.en[FIRST+2]) begin
      mprod <= 24'(rs4) * 24'(MIN_RECIP);
      h5    <= h4;
      rs5   <= rs4;
    end
  end

  // minute and second, then delay to line up with the date
  assign m_est = mprod[23:18];

  always_ff @(posedge clk) begin
    if (ctl.en[FIRST+3]) begin
      h_dly[0] <= h5;
      m_dly[0] <= m_est;
      s_dly[0] <= 6'(rs5 - 12'(m_est) * 12'(SECS_PER_MIN));
    end
    for (int k = 1; k <= DLY; k++) begin
      if (ctl.en[FIRST+3+k]) begin
        h_dly[k] <= h_dly[k-1];
        m_dly[k] <= m_dly[k-1];
        s_dly[k] <= s_dly[k-1];
      end
    end
  end

  assign hour   = h_dly[DLY];
  assign minute = m_dly[DLY];
  assign second = s_dly[DLY];

  // the hour remainder stays inside one hour
  assert property (@(posedge clk) disable iff (rst)
    ctl.vld[FIRST+1] |-> (rs4 < SECS_PER_HOUR))
    else $error("seconds within hour out of range");

endmodule

@@ src/epsc_civil_date.sv @@
module epsc_civil_date (
  input  logic                clk,
  input  logic                rst,
  input  epsc_pkg::pipe_ctl_t ctl,
  input  epsc_pkg::days_t     days,
  output logic [11:0]         year,
  output logic [3:0]          month,
  output logic [4:0]          day
);
  import epsc_pkg::*;

  localparam int S = STG_DATE_IN;

  logic [19:0] z;
  logic        z_era5;
  logic [17:0] doe3;
  logic        era3;
  logic [31:0] p1460;
  logic [2:0]  corr4;
  logic [17:0] doe4;
  logic        era4;
  logic [17:0] a5;
  logic [17:0] doe5;
  logic        era5;
  logic [34:0] py6;
  logic [17:0] doe6;
  logic        era6;
  logic [8:0]  yoe_est;
  logic [17:0] yoe_days;
  logic [8:0]  yoe7;
  logic [8:0]  doy7;
  logic        era7;
  logic [23:0] pm8;
  logic [8:0]  yoe8;
  logic [8:0]  doy8;
  logic        era8;
  logic [3:0]  mp;
  logic [3:0]  m_calc;
  logic [2:0]  c_ge;

  // shift to a march-based day count and split off the era
  assign z      = 20'(days) + SHIFT_TO_MARCH;
  assign z_era5 = (z >= ERA5_START);

  always_ff @(posedge clk) begin
    if (ctl.en[S]) begin
      era3 <= z_era5;
      doe3 <= z_era5 ? 18'(z - ERA5_START) : 18'(z - ERA4_START);
    end
  end

  // leap corrections: four-year count by reciprocal, centuries by compare
  assign c_ge = 3'(doe3 >= DOE_CENTURY1) + 3'(doe3 >= DOE_CENTURY2)
              + 3'(doe3 >= DOE_CENTURY3) + 3'(doe3 >= DOE_LAST)
              - 3'(doe3 == DOE_LAST);

  always_ff @(posedge clk) begin
    if (ctl.en[S+1]) begin
      p1460 <= 32'(doe3[17:2]) * 32'(QUAD_RECIP);
      corr4 <= c_ge;
      doe4  <= doe3;
      era4  <= era3;
    end
  end

  // day count with leap days removed
  always_ff @(posedge clk) begin
    if (ctl.en[S+2]) begin
      a5   <= doe4 - 18'(p1460[31:24]) + 18'(corr4);
      doe5 <= doe4;
      era5 <= era4;
    end
  end

  // year of era by reciprocal
  always_ff @(posedge clk) begin
    if (ctl.en[S+3]) begin
      py6  <= 35'(a5) * 35'(YEAR_RECIP);
      doe6 <= doe5;
      era6 <= era5;
    end
  end

  // day of the march-based year
  assign yoe_est  = py6[34:26];
  assign yoe_days = 18'(yoe_est) * 18'(DAYS_PER_YEAR) + 18'(yoe_est[8:2])
                  - 18'(5'((14'(yoe_est) * 14'(CENT_RECIP)) >> 12));

  always_ff @(posedge clk) begin
    if (ctl.en[S+4]) begin
      yoe7 <= yoe_est;
      doy7 <= 9'(doe6 - yoe_days);
      era7 <= era6;
    end
  end

  // march-based month by reciprocal
  always_ff @(posedge clk) begin
    if (ctl.en[S+5]) begin
      pm8  <= (24'(doy7) * 24'd5 + 24'd2) * 24'(MONTH_RECIP);
      yoe8 <= yoe7;
      doy8 <= doy7;
      era8 <= era7;
    end
  end

  // calendar month, day and year
  assign mp     = pm8[23:20];
  assign m_calc = (mp < 4'd10) ? 4'(mp + 4'd3) : 4'(mp - 4'd9);

  always_ff @(posedge clk) begin
    if (ctl.en[S+6]) begin
      month <= m_calc;
      day   <= 5'(doy8 - month_start(mp) + 9'd1);
      year  <= 12'(yoe8) + (era8 ? ERA5_YEAR : ERA4_YEAR)
             + 12'(m_calc <= 4'd2);
    end
  end

  // day of era never passes the last day of the era
  assert property (@(posedge clk) disable iff (rst)
    ctl.vld[S] |-> (doe3 <= DOE_LAST))
    else $error("day of era out of range");

  // day of year fits a leap year
  assert property (@(posedge clk) disable iff (rst)
    ctl.vld[S+4] |-> (doy7 < 9'd366))
    else $error("day of year out of range");

endmodule

@@ src/epoch_seconds_to_calendar.sv @@
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into the
// UTC date and time of day (year, month, day, hour, minute, second). The
// block is a ten-stage pipeline; the result of an item is offered from the
// last stage, and while the output does not stall, one item can be taken
// in every clock cycle.
// Each stage holds one item and loads whenever its successor moves or it is
// empty, so a stall at the output holds every item in place and empty slots
// close up; epoch.ready is combinational from calendar.ready through that
// stage chain. Stages 0 to 2 split the count into whole days and seconds of
// the day; stages 3 to 9 form the time of day and the Gregorian date in
// parallel, dividing by constants through reciprocals, shifts or compares.
module epoch_seconds_to_calendar (
  input  logic              clk,
  input  logic              rst,
  epsc_in_if.sink           epoch,
  epsc_out_if.source        calendar
);
  import epsc_pkg::*;

  pipe_ctl_t ctl;
  days_t     days;
  sod_t      sod;

  // stage valid bits and load enables
  epsc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (epoch.valid),
    .out_ready (calendar.ready),
    .in_ready  (epoch.ready),
    .out_valid (calendar.valid),
    .ctl       (ctl)
  );

  // whole days and seconds of the day
  epsc_day_split u_split (
    .clk           (clk),
    .ctl           (ctl),
    .epoch_seconds (epoch.epoch_seconds),
    .days          (days),
    .sod           (sod)
  );

  // hour, minute, second
  epsc_time_of_day u_tod (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sod    (sod),
    .hour   (calendar.hour),
    .minute (calendar.minute),
    .second (calendar.second)
  );

  // year, month, day
  epsc_civil_date u_date (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .days  (days),
    .year  (calendar.year),
    .month (calendar.month),
    .day   (calendar.day)
  );

endmodule

@@ tb/epoch_seconds_to_calendar_test.sv @@
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_test;

  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 240;
  localparam int PHASE_ITEMS  = 177;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  typedef struct {
    logic [31:0] secs;
    calendar_t   date;
  } date_due_t;

  // scoreboard: converts each accepted count, checks results in order
  class calendar_board;
    date_due_t dates_due[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    // civil-from-days over unsigned 32-bit arithmetic
    function calendar_t civil_date(input logic [31:0] secs);
      int unsigned t, sod, days, z, era, doe, yoe, doy, mp, d, m, y;
      calendar_t   r;
      t    = secs;
      sod  = t % 86400;
      days = t / 86400;
      z    = days + 719468;
      era  = z / 146097;
      doe  = z - era * 146097;
      yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp   = (5 * doy + 2) / 153;
      d    = doy - (153 * mp + 2) / 5 + 1;
      m    = (mp < 10) ? mp + 3 : mp - 9;
      y    = yoe + era * 400 + ((m <= 2) ? 1 : 0);
      r.year   = 12'(y);
      r.month  = 4'(m);
      r.day    = 5'(d);
      r.hour   = 5'(sod / 3600);
      r.minute = 6'((sod % 3600) / 60);
      r.second = 6'(sod % 60);
      return r;
    endfunction

    function void note_epoch(input logic [31:0] secs);
      date_due_t e;
      e.secs = secs;
      e.date = civil_date(secs);
      dates_due.push_back(e);
    endfunction

    function void check_date(input calendar_t got);
      date_due_t e;
      logic      bad;
      if (dates_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result %0d-%0d-%0d %0d:%0d:%0d", got.year, got.month,
                   got.day, got.hour, got.minute, got.second);
        return;
      end
      e   = dates_due.pop_front();
      bad = (e.date.year != got.year) || (e.date.month != got.month) ||
            (e.date.day != got.day) || (e.date.hour != got.hour) ||
            (e.date.minute != got.minute) || (e.date.second != got.second);
      if (bad) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("mismatch for %0d: expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
                   e.secs, e.date.year, e.date.month, e.date.day, e.date.hour,
                   e.date.minute, e.date.second, got.year, got.month, got.day,
                   got.hour, got.minute, got.second);
      end
    endfunction

    function int pending();
      return dates_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  epsc_in_if  epoch_ch ();
  epsc_out_if calendar_ch ();

  epoch_seconds_to_calendar uut (
    .clk      (clk),
    .rst      (rst),
    .epoch    (epoch_ch),
    .calendar (calendar_ch)
  );

  always #4 clk = ~clk;

  calendar_board board = new();
  int            rcv_idle_pct = 63;
  logic          hold_req = 1'b0;
  logic          hold_taken = 1'b0;
  int            hold_left = 0;
  int            quiet_cycles = 0;
  logic [31:0]   corner_epochs [0:21];

  // random counts, biased toward day edges and both ends of the range
  function automatic logic [31:0] pick_epoch();
    longint unsigned v;
    int unsigned     days;
    int unsigned     sel;
    sel = $urandom_range(9);
    case (sel)
      4, 5: begin
        days = $urandom_range(49710, 0);
        case ($urandom_range(4))
          0:       v = longint'(days) * 86400;
          1:       v = longint'(days) * 86400 + 1;
          2:       v = longint'(days) * 86400 + 86399;
          3:       v = longint'(days) * 86400 + 86398;
          default: v = longint'(days) * 86400 + $urandom_range(86399, 0);
        endcase
        if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      end
      6:       v = 32'hFFFF_FFFF - $urandom_range(200000, 0);
      7:       v = $urandom_range(200000, 0);
      default: v = $urandom;
    endcase
    return v[31:0];
  endfunction

  // idle cycle by cycle at the given rate, then offer one count until taken
  task automatic send_epoch(input logic [31:0] secs, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      epoch_ch.valid         <= 1'b0;
      epoch_ch.epoch_seconds <= $urandom;
      @(posedge clk);
    end
    epoch_ch.valid         <= 1'b1;
    epoch_ch.epoch_seconds <= secs;
    do @(posedge clk); while (!epoch_ch.ready);
    board.note_epoch(secs);
  endtask

  // stop offering until every pending date has come back
  task automatic drain_results();
    epoch_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // receiver: random back-pressure, or a long hold-off on request
  initial begin
    calendar_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        calendar_ch.ready <= 1'b0;
      end else begin
        calendar_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && calendar_ch.valid && calendar_ch.ready)
      board.check_date({calendar_ch.year, calendar_ch.month, calendar_ch.day,
                        calendar_ch.hour, calendar_ch.minute, calendar_ch.second});
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (epoch_ch.valid && epoch_ch.ready) ||
        (calendar_ch.valid && calendar_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int snd_idle_pct;
    epoch_ch.valid         = 1'b0;
    epoch_ch.epoch_seconds = 32'd0;
    // zero, minute/hour/day edges, leap days, year ends, sign bit, top of range
    corner_epochs = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                      32'd86400, 32'd68169600, 32'd94694399, 32'd946684799,
                      32'd946684800, 32'd951782400, 32'd951868800, 32'd2147483647,
                      32'd2147483648, 32'h5555_5555, 32'hAAAA_AAAA, 32'd4107542399,
                      32'd4294944000, 32'd4294967294, 32'd4294967295};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners under the first idling mix
    rcv_idle_pct = 63;
    foreach (corner_epochs[i]) send_epoch(corner_epochs[i], 28);
    drain_results();

    // random phases: sender light/receiver heavy, swapped, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin snd_idle_pct = 28; rcv_idle_pct = 63; end
        1: begin snd_idle_pct = 63; rcv_idle_pct = 28; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long output stall while items keep coming, pipeline backs up
        if (phase == 2 && n == 40) hold_req <= 1'b1;
        send_epoch(pick_epoch(), snd_idle_pct);
      end
      drain_results();
    end

    repeat (2 * epsc_pkg::NSTAGE) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
